@@ rtl/uv_sphere_quad_vertex_gen_macros.svh @@
// Assertion macros used by the checker of the UV sphere vertex generator.
`ifndef UV_SPHERE_QUAD_VERTEX_GEN_MACROS_SVH
`define UV_SPHERE_QUAD_VERTEX_GEN_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define UVS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("uv sphere vertex check failed");

// Check a consequent in the cycle after its antecedent.
`define UVS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("uv sphere vertex check failed");

`endif

@@ rtl/uvs_pkg.sv @@
// Shared constants, types and helpers of the UV sphere vertex generator.
package uvs_pkg;

    localparam int SEG_W             = 11;
    localparam int CELL_W            = 10;
    localparam int PH_W              = 24;
    localparam int QUO_W             = 26;
    localparam int DVD_W             = 36;
    localparam int DIV_BITS          = 4;
    localparam int DIV_STAGES        = DVD_W / DIV_BITS;
    localparam int HORNER_STEPS      = 4;

    localparam logic [SEG_W-1:0] DEFAULT_DIVISIONS = 11'd16;
    localparam logic [SEG_W-1:0] MAX_SEGMENTS      = 11'd1024;

    localparam logic [1:0] CFG_LAT_SEGMENTS = 2'd0;
    localparam logic [1:0] CFG_LON_SEGMENTS = 2'd1;

    localparam logic [1:0] CORNER_D = 2'd3;

    localparam logic [33:0] PI_Q32 = 34'd13493037705;
    localparam logic [16:0] PI_HI  = PI_Q32[33:17];
    localparam logic [16:0] PI_LO  = PI_Q32[16:0];
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    // Reciprocals for exact truncating division by the series divisors.
    // Row 0 serves the sine chain, row 1 the cosine chain.
    localparam logic [31:0] RECIP [2][HORNER_STEPS] = '{
        '{32'(((64'd1 << 38) + 64'd71) / 64'd72),
          32'(((64'd1 << 37) + 64'd41) / 64'd42),
          32'(((64'd1 << 36) + 64'd19) / 64'd20),
          32'(((64'd1 << 34) + 64'd5) / 64'd6)},
        '{32'(((64'd1 << 38) + 64'd89) / 64'd90),
          32'(((64'd1 << 37) + 64'd55) / 64'd56),
          32'(((64'd1 << 36) + 64'd29) / 64'd30),
          32'(((64'd1 << 35) + 64'd11) / 64'd12)}
    };
    localparam int RSHIFT [2][HORNER_STEPS] = '{'{38, 37, 36, 34}, '{38, 37, 36, 35}};

    typedef struct packed {
        logic       valid;
        logic [1:0] corner;
    } div_tag_t;

    typedef struct packed {
        logic [1:0]  corner;
        logic [16:0] tex_u;
        logic [16:0] tex_v;
    } sc_tag_t;

    // Effective segment count: zero selects the default, large values saturate.
    function automatic logic [SEG_W-1:0] eff_count(input logic [SEG_W-1:0] r);
        logic [SEG_W-1:0] n;
        n = r;
        if (r == '0)
            n = DEFAULT_DIVISIONS;
        else if (r > MAX_SEGMENTS)
            n = MAX_SEGMENTS;
        return n;
    endfunction

endpackage

@@ rtl/uvs_div.sv @@
// Pipelined restoring divider: index * 2^25 over segment count, two lanes.
module uvs_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  uvs_pkg::div_tag_t                tag_in,
    input  logic [10:0]                      lat_idx,
    input  logic [10:0]                      lon_idx,
    input  logic [10:0]                      lat_n,
    input  logic [10:0]                      lon_n,
    output uvs_pkg::div_tag_t                tag_out,
    output logic [25:0]                      lat_quo,
    output logic [25:0]                      lon_quo
);
    import uvs_pkg::*;

    typedef struct packed {
        logic [SEG_W-1:0] rem;
        logic [QUO_W-1:0] quo;
        logic [DVD_W-1:0] dvd;
    } lane_t;

    lane_t    lat_reg [DIV_STAGES];
    lane_t    lon_reg [DIV_STAGES];
    div_tag_t tag_reg [DIV_STAGES];

    // Retire DIV_BITS quotient bits, one compare and subtract each.
    function automatic lane_t div_step(input lane_t a, input logic [SEG_W-1:0] n);
        lane_t       r;
        logic [SEG_W:0] r12;
        r = a;
        for (int b = 0; b < DIV_BITS; b++)
        begin
            r12   = {r.rem, r.dvd[DVD_W-1]};
            r.dvd = {r.dvd[DVD_W-2:0], 1'b0};
            if (r12 >= {1'b0, n})
            begin
                r.rem = SEG_W'(r12 - {1'b0, n});
                r.quo = {r.quo[QUO_W-2:0], 1'b1};
            end
            else
            begin
                r.rem = r12[SEG_W-1:0];
                r.quo = {r.quo[QUO_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    lane_t lat_init;
    lane_t lon_init;

    always_comb
    begin
        lat_init = '{rem: '0, quo: '0, dvd: {lat_idx, 25'd0}};
        lon_init = '{rem: '0, quo: '0, dvd: {lon_idx, 25'd0}};
    end

    // Advance the valid bits and tags every cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < DIV_STAGES; s++)
                tag_reg[s] <= '0;
        end
        else
        begin
            tag_reg[0] <= tag_in;
            for (int s = 1; s < DIV_STAGES; s++)
                tag_reg[s] <= tag_reg[s-1];
        end
    end

    // Advance the partial quotients.
    always_ff @(posedge clk)
    begin
        lat_reg[0] <= div_step(lat_init, lat_n);
        lon_reg[0] <= div_step(lon_init, lon_n);
        for (int s = 1; s < DIV_STAGES; s++)
        begin
            lat_reg[s] <= div_step(lat_reg[s-1], lat_n);
            lon_reg[s] <= div_step(lon_reg[s-1], lon_n);
        end
    end

    assign tag_out = tag_reg[DIV_STAGES-1];
    assign lat_quo = lat_reg[DIV_STAGES-1].quo;
    assign lon_quo = lon_reg[DIV_STAGES-1].quo;

endmodule

@@ rtl/uvs_sincos.sv @@
// Pipelined sine and cosine of a 24-bit phase, Q30 magnitude and sign.
module uvs_sincos (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [23:0]         phase,
    input  uvs_pkg::sc_tag_t    tag_in,
    output logic                out_valid,
    output uvs_pkg::sc_tag_t    tag_out,
    output logic [30:0]         sin_mag,
    output logic                sin_neg,
    output logic [30:0]         cos_mag,
    output logic                cos_neg
);
    import uvs_pkg::*;

    localparam int LINE_LEN = 16;

    typedef struct packed {
        logic        valid;
        sc_tag_t     tag;
        logic [1:0]  quad;
        logic        fold;
        logic [29:0] x;
        logic [29:0] x2;
    } line_t;

    line_t       line_reg [LINE_LEN];
    logic [38:0] hi_reg;
    logic [38:0] lo_reg;
    logic [59:0] xx_reg;
    logic [62:0] pm_reg   [2][HORNER_STEPS];
    logic [30:0] t_reg    [2][HORNER_STEPS];
    logic [60:0] prod_reg [2][1:HORNER_STEPS];

    logic [21:0] frac;
    logic        fold_w;
    logic [21:0] g;
    logic [56:0] xsum;
    logic [60:0] xxr;
    line_t       line1_next;
    line_t       line3_next;

    function automatic logic [30:0] rnd_q30(input logic [60:0] p);
        logic [61:0] s;
        s = {1'b0, p} + 62'h2000_0000;
        return s[60:30];
    endfunction

    // Fold the phase into the first eighth of a turn.
    always_comb
    begin
        frac   = phase[21:0];
        fold_w = frac > 22'h20_0000;
        g      = fold_w ? 22'(23'h40_0000 - {1'b0, frac}) : frac;
        xsum   = {hi_reg, 17'd0} + 57'(lo_reg) + 57'h100_0000;
        xxr    = {1'b0, xx_reg} + 61'h2000_0000;
    end

    // Attach the angle and its square as they become ready.
    always_comb
    begin
        line1_next    = line_reg[0];
        line1_next.x  = xsum[54:25];
        line3_next    = line_reg[2];
        line3_next.x2 = xxr[59:30];
    end

    // Carry valid, tag and shared operands down the line.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < LINE_LEN; n++)
                line_reg[n] <= '0;
        end
        else
        begin
            line_reg[0] <= '{valid: in_valid, tag: tag_in, quad: phase[23:22],
                             fold: fold_w, x: '0, x2: '0};
            line_reg[1] <= line1_next;
            line_reg[2] <= line_reg[1];
            line_reg[3] <= line3_next;
            for (int n = 4; n < LINE_LEN; n++)
                line_reg[n] <= line_reg[n-1];
        end
    end

    // Angle to radians, square, then Horner steps of both series.
    always_ff @(posedge clk)
    begin
        hi_reg <= 39'(g) * 39'(PI_HI);
        lo_reg <= 39'(g) * 39'(PI_LO);
        xx_reg <= 60'(line_reg[1].x) * 60'(line_reg[1].x);
        for (int l = 0; l < 2; l++)
        begin
            pm_reg[l][0] <= 63'(line_reg[3].x2) * 63'(RECIP[l][0]);
            t_reg[l][0]  <= ONE_Q30 - 31'(pm_reg[l][0] >> RSHIFT[l][0]);
            for (int h = 1; h < HORNER_STEPS; h++)
            begin
                prod_reg[l][h] <= 61'(line_reg[3*h+2].x2) * 61'(t_reg[l][h-1]);
                pm_reg[l][h]   <= 63'(rnd_q30(prod_reg[l][h])) * 63'(RECIP[l][h]);
                t_reg[l][h]    <= ONE_Q30 - 31'(pm_reg[l][h] >> RSHIFT[l][h]);
            end
        end
        prod_reg[0][HORNER_STEPS] <= 61'(line_reg[14].x) * 61'(t_reg[0][HORNER_STEPS-1]);
        prod_reg[1][HORNER_STEPS] <= 61'(line_reg[14].x2) * 61'(t_reg[1][HORNER_STEPS-1]);
    end

    logic [30:0] s0;
    logic [30:0] c0;
    logic [30:0] cr;
    logic [30:0] s_sel;
    logic [30:0] c_sel;

    // Close the series and swap sine and cosine on folded angles.
    always_comb
    begin
        s0    = rnd_q30(prod_reg[0][HORNER_STEPS]);
        cr    = rnd_q30(prod_reg[1][HORNER_STEPS]);
        c0    = ONE_Q30 - {1'b0, cr[30:1]};
        s_sel = line_reg[15].fold ? c0 : s0;
        c_sel = line_reg[15].fold ? s0 : c0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else
            out_valid <= line_reg[15].valid;
    end

    always_ff @(posedge clk)
    begin
        tag_out <= line_reg[15].tag;
        case (line_reg[15].quad)
            2'd0:
            begin
                sin_mag <= s_sel; sin_neg <= 1'b0; cos_mag <= c_sel; cos_neg <= 1'b0;
            end
            2'd1:
            begin
                sin_mag <= c_sel; sin_neg <= 1'b0; cos_mag <= s_sel; cos_neg <= 1'b1;
            end
            2'd2:
            begin
                sin_mag <= s_sel; sin_neg <= 1'b1; cos_mag <= c_sel; cos_neg <= 1'b1;
            end
            default:
            begin
                sin_mag <= c_sel; sin_neg <= 1'b1; cos_mag <= s_sel; cos_neg <= 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/uv_sphere_quad_vertex_gen.sv @@
// Top level of the UV sphere quad vertex generator.
// Usage:
//   Pulse start with lat_cell and lon_cell while busy is low to hand in one
//   quad; the item is taken at that clock edge. The block then issues the
//   quad's four corners a, b, c, d into its pipeline, one per cycle, and holds
//   busy high until it reaches corner d, when a new quad can already be taken.
//   The corners appear on the result ports in order a, b, c, d in consecutive
//   cycles, each for one cycle with vertex_valid high; last marks corner d.
//   The depth comes from the issue register, a 9-stage divider (index over
//   segment count), the phase register, a 17-stage sine/cosine series
//   pipeline, the position multiply stage and the output register.
//   The receiver cannot stall; results are never held.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data write
//   lat_segments (index 0) or lon_segments (index 1); cfg_ready is always high.
//   Write only while the block is idle.
//   Reset clears both segment registers (default division of 16) and empties
//   the pipeline.
module uv_sphere_quad_vertex_gen (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [9:0]         lat_cell,
    input  logic [9:0]         lon_cell,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [10:0]        cfg_data,
    output logic               vertex_valid,
    output logic [1:0]         corner,
    output logic signed [15:0] pos_x,
    output logic signed [15:0] pos_y,
    output logic signed [15:0] pos_z,
    output logic [16:0]        tex_u,
    output logic [16:0]        tex_v,
    output logic               last
);
    import uvs_pkg::*;

    logic [SEG_W-1:0]  lat_seg_reg;
    logic [SEG_W-1:0]  lon_seg_reg;
    logic [SEG_W-1:0]  nlat;
    logic [SEG_W-1:0]  nlon;
    logic              accept;
    logic [CELL_W-1:0] i_cl;
    logic [CELL_W-1:0] j_cl;

    logic              act_reg;
    logic [1:0]        cnt_reg;
    logic [CELL_W-1:0] i_reg;
    logic [CELL_W-1:0] j_reg;
    div_tag_t          iss_tag_reg;
    logic [SEG_W-1:0]  iss_p_reg;
    logic [SEG_W-1:0]  iss_q_reg;

    assign cfg_ready = 1'b1;
    assign nlat      = eff_count(lat_seg_reg);
    assign nlon      = eff_count(lon_seg_reg);
    assign busy      = act_reg && (cnt_reg != CORNER_D);
    assign accept    = start && !busy;

    // Clamp cell indices below the effective counts.
    always_comb
    begin
        i_cl = ({1'b0, lat_cell} >= nlat) ? CELL_W'(nlat - 11'd1) : lat_cell;
        j_cl = ({1'b0, lon_cell} >= nlon) ? CELL_W'(nlon - 11'd1) : lon_cell;
    end

    // Write configuration registers; drop writes beyond the list.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat_seg_reg <= '0;
            lon_seg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LAT_SEGMENTS: lat_seg_reg <= cfg_data;
                CFG_LON_SEGMENTS: lon_seg_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Step through the four corners of the held item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg     <= 1'b0;
            cnt_reg     <= '0;
            iss_tag_reg <= '0;
        end
        else
        begin
            iss_tag_reg <= '{valid: act_reg, corner: cnt_reg};
            if (accept)
            begin
                act_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (act_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == CORNER_D)
                    act_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            i_reg <= i_cl;
            j_reg <= j_cl;
        end
        iss_p_reg <= {1'b0, i_reg} + SEG_W'(cnt_reg[0]);
        iss_q_reg <= {1'b0, j_reg} + SEG_W'(cnt_reg[1]);
    end

    div_tag_t    div_tag;
    logic [25:0] lat_quo;
    logic [25:0] lon_quo;

    uvs_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (iss_tag_reg),
        .lat_idx (iss_p_reg),
        .lon_idx (iss_q_reg),
        .lat_n   (nlat),
        .lon_n   (nlon),
        .tag_out (div_tag),
        .lat_quo (lat_quo),
        .lon_quo (lon_quo)
    );

    // Round the quotients into phases and texture coordinates.
    logic          ph_valid_reg;
    logic [23:0]   lat_ph_reg;
    logic [23:0]   lon_ph_reg;
    sc_tag_t       ph_tag_reg;
    logic [25:0]   lat_r23;
    logic [25:0]   lat_r16;
    logic [25:0]   lon_r24;
    logic [25:0]   lon_r16;

    always_comb
    begin
        lat_r23 = ((lat_quo >> 1) + 26'd1) >> 1;
        lat_r16 = ((lat_quo >> 8) + 26'd1) >> 1;
        lon_r24 = (lon_quo + 26'd1) >> 1;
        lon_r16 = ((lon_quo >> 8) + 26'd1) >> 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ph_valid_reg <= 1'b0;
        else
            ph_valid_reg <= div_tag.valid;
    end

    always_ff @(posedge clk)
    begin
        lat_ph_reg        <= lat_r23[23:0] + 24'hC0_0000;
        lon_ph_reg        <= lon_r24[23:0];
        ph_tag_reg.corner <= div_tag.corner;
        ph_tag_reg.tex_u  <= lon_r16[16:0];
        ph_tag_reg.tex_v  <= 17'h1_0000 - lat_r16[16:0];
    end

    logic        sc_valid;
    sc_tag_t     sc_tag;
    logic [30:0] sla;
    logic [30:0] cla;
    logic [30:0] slo;
    logic [30:0] clo;
    logic        nsla;
    logic        ncla;
    logic        nslo;
    logic        nclo;

    uvs_sincos u_lat_sc (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ph_valid_reg),
        .phase     (lat_ph_reg),
        .tag_in    (ph_tag_reg),
        .out_valid (sc_valid),
        .tag_out   (sc_tag),
        .sin_mag   (sla),
        .sin_neg   (nsla),
        .cos_mag   (cla),
        .cos_neg   (ncla)
    );

    uvs_sincos u_lon_sc (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ph_valid_reg),
        .phase     (lon_ph_reg),
        .tag_in    (ph_tag_reg),
        .out_valid (),
        .tag_out   (),
        .sin_mag   (slo),
        .sin_neg   (nslo),
        .cos_mag   (clo),
        .cos_neg   (nclo)
    );

    // Form the position products.
    logic        mv_reg;
    sc_tag_t     mtag_reg;
    logic [61:0] px_reg;
    logic [61:0] pz_reg;
    logic [30:0] py_reg;
    logic        nx_reg;
    logic        ny_reg;
    logic        nz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_reg       <= 1'b0;
            vertex_valid <= 1'b0;
        end
        else
        begin
            mv_reg       <= sc_valid;
            vertex_valid <= mv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mtag_reg <= sc_tag;
        px_reg   <= 62'(cla) * 62'(clo);
        pz_reg   <= 62'(cla) * 62'(slo);
        py_reg   <= sla;
        nx_reg   <= ncla != nclo;
        ny_reg   <= nsla;
        nz_reg   <= ncla != nslo;
    end

    // Round to Q1.14 and apply the signs.
    logic [62:0] rx;
    logic [62:0] rz;
    logic [31:0] ry;
    logic [15:0] mx;
    logic [15:0] my;
    logic [15:0] mz;

    always_comb
    begin
        rx = {1'b0, px_reg} + 63'h2000_0000_0000;
        rz = {1'b0, pz_reg} + 63'h2000_0000_0000;
        ry = {1'b0, py_reg} + 32'h8000;
        mx = rx[61:46];
        mz = rz[61:46];
        my = ry[31:16];
    end

    always_ff @(posedge clk)
    begin
        corner <= mtag_reg.corner;
        tex_u  <= mtag_reg.tex_u;
        tex_v  <= mtag_reg.tex_v;
        last   <= mtag_reg.corner == CORNER_D;
        pos_x  <= nx_reg ? -mx : mx;
        pos_y  <= ny_reg ? -my : my;
        pos_z  <= nz_reg ? -mz : mz;
    end

endmodule

@@ rtl/uvs_checker.sv @@
// Port-level checker of the UV sphere vertex generator and its bind.
`include "uv_sphere_quad_vertex_gen_macros.svh"

module uvs_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               vertex_valid,
    input logic [1:0]         corner,
    input logic signed [15:0] pos_y,
    input logic               last
);
    // Busy follows every accepted item.
    `UVS_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy)
    // Last marks corner d and nothing else.
    `UVS_ASSERT_SAME(a_last_on_d, vertex_valid, last == (corner == 2'd3))
    // Corners of a quad come in consecutive cycles.
    `UVS_ASSERT_NEXT(a_corner_run, vertex_valid && corner != 2'd3, vertex_valid && corner == $past(corner) + 2'd1)
    // Corner c shares the latitude of corner a.
    `UVS_ASSERT_SAME(a_same_band, vertex_valid && corner == 2'd2, pos_y == $past(pos_y, 2))
endmodule

bind uv_sphere_quad_vertex_gen uvs_checker u_chk (.*);
